[rtl/insertion_sort_engine_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the insertion sort engine
// Checks sampled at the rising edge of clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef INSERTION_SORT_ENGINE_DEFINES_SVH
`define INSERTION_SORT_ENGINE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ISE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("insertion sort engine check failed");

// Consequent must hold in the cycle after the antecedent.
`define ISE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("insertion sort engine check failed");

`endif

[rtl/ise_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Insertion sort engine package
// Sizes, slot and control types, and the key compare shared by the cells.
// ---------------------------------------------------------------------------
package ise_pkg;

  localparam int unsigned MAX_KEYS        = 64;
  localparam int unsigned KEY_WIDTH       = 32;
  localparam int unsigned IO_KEY_WIDTH    = 32;
  localparam int unsigned MODE_WIDTH      = 2;
  localparam int unsigned MODE_DESC_BIT   = 0;
  localparam int unsigned MODE_SIGNED_BIT = 1;

  typedef logic [KEY_WIDTH-1:0]  key_t;
  typedef logic [MODE_WIDTH-1:0] mode_t;

  typedef struct packed {
    logic valid;
    key_t key;
  } slot_t;

  typedef enum logic [2:0] {
    OP_HOLD      = 3'b001,
    OP_INSERT    = 3'b010,
    OP_SHIFT_OUT = 3'b100
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    mode_t    mode;
    key_t     key;
  } cell_ctl_t;

  // True when stored key a must sit after new key b under the given mode.
  function automatic logic orders_after(key_t a, key_t b, mode_t mode);
    key_t sign_flip;
    key_t a_c;
    key_t b_c;
    sign_flip = '0;
    sign_flip[KEY_WIDTH-1] = mode[MODE_SIGNED_BIT];
    a_c = a ^ sign_flip;
    b_c = b ^ sign_flip;
    if (mode[MODE_DESC_BIT]) begin
      return a_c < b_c;
    end
    return a_c > b_c;
  endfunction

endpackage

[rtl/ise_in_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Key input channel
// Valid/ready channel carrying one key and its end-of-set mark.
// ---------------------------------------------------------------------------
interface ise_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] key;
  logic        last_in;

  modport source (output valid, output key, output last_in, input ready);
  modport sink   (input valid, input key, input last_in, output ready);
endinterface

[rtl/ise_out_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted output channel
// Valid/ready channel carrying one sorted key with its flags.
// ---------------------------------------------------------------------------
interface ise_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sorted_key;
  logic        last_out;
  logic        overflow;

  modport source (output valid, output sorted_key, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_key, input last_out, input overflow,
                  output ready);
endinterface

[rtl/insertion_sort_engine.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Insertion sort engine
// Stable sort of a set of keys in a chain of cells, one key per slot.
// ---------------------------------------------------------------------------
// Usage:
//   key_chan takes one key per transaction; last_in marks the final key of
//   a set. Each key is inserted into the chain in the cycle it is accepted,
//   so keys stream in at one per cycle until the set ends.
//   After the last key, key_chan.ready drops and the chain drains through
//   sorted_chan, one sorted key per cycle while the receiver is ready,
//   starting the cycle after the last key is accepted. last_out marks the
//   final key; overflow is set on every key of a set in which keys beyond
//   the 64 slots were dropped. The drain through the head cell bounds the
//   set-to-set rate: key_chan.ready stays low until the set has drained.
//   When the receiver stalls, the head cell holds its key and the chain
//   stands still. Reset empties the chain and clears compare_mode; there is
//   no clearing pass. compare_mode (cfg_we/cfg_data) is written between sets:
//   bit0 selects descending order, bit1 signed compare.
// ---------------------------------------------------------------------------
`include "insertion_sort_engine_defines.svh"

module insertion_sort_engine
  import ise_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  ise_in_if.sink                key_chan,
  ise_out_if.source             sorted_chan,
  input  logic                  cfg_we,
  input  logic [MODE_WIDTH-1:0] cfg_data
);

  mode_t         compare_mode;
  logic          draining;
  logic          dropped;
  cell_ctl_t     ctl;
  slot_t         slots     [MAX_KEYS];
  logic [MAX_KEYS-1:0] after_vec;
  logic [MAX_KEYS-1:0] run_vec;
  logic [MAX_KEYS-1:0] valid_vec;
  logic          full;
  logic          in_fire;
  logic          out_fire;

  assign full     = slots[MAX_KEYS-1].valid;
  assign in_fire  = key_chan.valid && key_chan.ready;
  assign out_fire = sorted_chan.valid && sorted_chan.ready;

  assign key_chan.ready = !draining;

  assign sorted_chan.valid      = draining && slots[0].valid;
  assign sorted_chan.sorted_key = IO_KEY_WIDTH'(slots[0].key);
  assign sorted_chan.last_out   = !slots[1].valid;
  assign sorted_chan.overflow   = dropped;

  always_comb begin
    ctl.mode = compare_mode;
    ctl.key  = key_chan.key[KEY_WIDTH-1:0];
    priority if (in_fire && !full) begin
      ctl.op = OP_INSERT;
    end else if (out_fire) begin
      ctl.op = OP_SHIFT_OUT;
    end else begin
      ctl.op = OP_HOLD;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_KEYS; gi++) begin : g_chain
      slot_t left_slot;
      slot_t right_slot;
      logic  run_left;

      // A cell moves only when it and every cell behind it order after the key.
      assign run_vec[gi]   = &after_vec[MAX_KEYS-1:gi];
      assign valid_vec[gi] = slots[gi].valid;

      if (gi == 0) begin : g_head
        assign left_slot = '0;
        assign run_left  = 1'b0;
      end else begin : g_body
        assign left_slot = slots[gi-1];
        assign run_left  = run_vec[gi-1];
      end

      if (gi == MAX_KEYS - 1) begin : g_tail
        assign right_slot = '0;
      end else begin : g_inner
        assign right_slot = slots[gi+1];
      end

      ise_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .run_self (run_vec[gi]),
        .run_left (run_left),
        .left     (left_slot),
        .right    (right_slot),
        .slot     (slots[gi]),
        .after    (after_vec[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_mode <= '0;
      draining     <= 1'b0;
      dropped      <= 1'b0;
    end else begin
      if (cfg_we) begin
        compare_mode <= cfg_data;
      end
      if (in_fire) begin
        if (full) begin
          dropped <= 1'b1;
        end
        if (key_chan.last_in) begin
          draining <= 1'b1;
        end
      end
      // Close the set once the final key leaves.
      if (out_fire && !slots[1].valid) begin
        draining <= 1'b0;
        dropped  <= 1'b0;
      end
    end
  end

  `ISE_ASSERT_SAME(a_valid_prefix, 1'b1, ((valid_vec + 1'b1) & valid_vec) == '0)
  `ISE_ASSERT_NEXT(a_insert_grows, in_fire && !full,
                   $countones(valid_vec) == $countones($past(valid_vec)) + 1)
  `ISE_ASSERT_NEXT(a_last_ends_set, out_fire && sorted_chan.last_out,
                   !draining && !dropped && !slots[0].valid)
  `ISE_ASSERT_SAME(a_flag_steady, draining && $past(draining) && !$past(rst), $stable(dropped))

endmodule

[rtl/ise_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Insertion sort cell
// Holds one slot of the sorted store; takes the new key or its left
// neighbor on insert, and its right neighbor while the store drains.
// ---------------------------------------------------------------------------
module ise_cell
  import ise_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      run_self,
  input  logic      run_left,
  input  slot_t     left,
  input  slot_t     right,
  output slot_t     slot,
  output logic      after
);

  logic slot_valid;
  key_t slot_key;

  assign slot  = '{valid: slot_valid, key: slot_key};
  // An empty slot sits after any key, so the run of moving cells ends at the tail.
  assign after = !slot_valid || orders_after(slot_key, ctl.key, ctl.mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else begin
      unique case (ctl.op)
        OP_INSERT: begin
          if (run_self) begin
            slot_valid <= run_left ? left.valid : 1'b1;
          end
        end
        OP_SHIFT_OUT: begin
          slot_valid <= right.valid;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_INSERT: begin
        if (run_self) begin
          slot_key <= run_left ? left.key : ctl.key;
        end
      end
      OP_SHIFT_OUT: begin
        slot_key <= right.key;
      end
      default: begin
      end
    endcase
  end

endmodule

[sim/insertion_sort_engine_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Insertion sort engine checker
// Watches both channels and the compare-mode writes. It keeps its own sorted
// store and, on each end-of-set key, queues the keys in the order the engine
// must return them. Each returned key is matched field by field against the
// head of that queue.
// ---------------------------------------------------------------------------
module insertion_sort_engine_checker
  import ise_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_we,
  input  mode_t cfg_data,
  ise_in_if     key_mon,
  ise_out_if    sorted_mon,
  output int    fail_count,
  output int    pending_count
);

  typedef struct packed {
    logic [IO_KEY_WIDTH-1:0] sorted_key;
    logic                    last_out;
    logic                    overflow;
  } sorted_entry_t;

  key_t          held_keys [MAX_KEYS];
  int            held_count;
  logic          keys_dropped;
  mode_t         sort_mode;
  sorted_entry_t sorted_expected [$];
  sorted_entry_t want;
  key_t          new_key;
  int            slot;
  logic          moves_back;
  int            mismatches;

  always @(posedge clk) begin
    if (rst) begin
      held_count   = 0;
      keys_dropped = 1'b0;
      sort_mode    = '0;
      sorted_expected.delete();
    end else begin
      if (sorted_mon.valid && sorted_mon.ready) begin
        if (sorted_expected.size() == 0) begin
          $error("sorted key %h arrived with nothing expected", sorted_mon.sorted_key);
          mismatches++;
        end else begin
          want = sorted_expected.pop_front();
          if (sorted_mon.sorted_key !== want.sorted_key) begin
            $error("sorted_key: expected %h, got %h", want.sorted_key, sorted_mon.sorted_key);
            mismatches++;
          end
          if (sorted_mon.last_out !== want.last_out) begin
            $error("last_out: expected %b, got %b", want.last_out, sorted_mon.last_out);
            mismatches++;
          end
          if (sorted_mon.overflow !== want.overflow) begin
            $error("overflow: expected %b, got %b", want.overflow, sorted_mon.overflow);
            mismatches++;
          end
        end
      end

      if (key_mon.valid && key_mon.ready) begin
        new_key = key_mon.key[KEY_WIDTH-1:0];
        if (held_count == MAX_KEYS) begin
          keys_dropped = 1'b1;
        end else begin
          // Scan back from the tail; only a strictly later key moves, which keeps ties stable.
          slot       = held_count;
          moves_back = 1'b1;
          while (slot > 0 && moves_back) begin
            if (sort_mode[MODE_SIGNED_BIT]) begin
              moves_back = sort_mode[MODE_DESC_BIT] ?
                           ($signed(held_keys[slot-1]) < $signed(new_key)) :
                           ($signed(held_keys[slot-1]) > $signed(new_key));
            end else begin
              moves_back = sort_mode[MODE_DESC_BIT] ? (held_keys[slot-1] < new_key) :
                                                      (held_keys[slot-1] > new_key);
            end
            if (moves_back) begin
              held_keys[slot] = held_keys[slot-1];
              slot--;
            end
          end
          held_keys[slot] = new_key;
          held_count++;
        end

        // End of set: a dropped last key still flushes what is held.
        if (key_mon.last_in) begin
          for (int i = 0; i < held_count; i++) begin
            want.sorted_key = IO_KEY_WIDTH'(held_keys[i]);
            want.last_out   = (i == held_count - 1);
            want.overflow   = keys_dropped;
            sorted_expected.push_back(want);
          end
          held_count   = 0;
          keys_dropped = 1'b0;
        end
      end

      if (cfg_we) begin
        sort_mode = cfg_data;
      end
    end
    fail_count    <= mismatches;
    pending_count <= sorted_expected.size();
  end

endmodule

[sim/insertion_sort_engine_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Insertion sort engine testbench
// Sends key sets of many sizes under all compare modes, including sets that
// overrun the store, with bursty input and a stalling receiver. The checker
// beside the engine predicts and compares; this module drives and decides.
// ---------------------------------------------------------------------------
module insertion_sort_engine_tb
  import ise_pkg::*;
();

  localparam mode_t MODE_ASC_UNSIGNED  = 2'b00;
  localparam mode_t MODE_DESC_UNSIGNED = 2'b01;
  localparam mode_t MODE_ASC_SIGNED    = 2'b10;
  localparam mode_t MODE_DESC_SIGNED   = 2'b11;

  localparam int RANDOM_ITEMS   = 500;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_AT        = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam logic [31:0] EDGE_KEYS [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                            32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF};

  logic        clk;
  logic        rst;
  logic        cfg_we;
  mode_t       cfg_data;
  int          fail_count;
  int          pending_count;
  int          burst_left;
  int          quiet_cycles;
  logic [31:0] batch [$];

  ise_in_if  key_chan ();
  ise_out_if sorted_chan ();

  insertion_sort_engine u_top (
    .clk         (clk),
    .rst         (rst),
    .key_chan    (key_chan),
    .sorted_chan (sorted_chan),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data)
  );

  insertion_sort_engine_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .key_mon       (key_chan),
    .sorted_mon    (sorted_chan),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Offer one key; open a new burst after a random gap when the current one runs out.
  task automatic offer_key(input logic [31:0] k, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        key_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
                                                 $urandom_range(1, 12);
    end
    key_chan.valid   <= 1'b1;
    key_chan.key     <= k;
    key_chan.last_in <= is_last;
    do @(posedge clk); while (!key_chan.ready);
    burst_left--;
  endtask

  task automatic send_batch();
    for (int i = 0; i < batch.size(); i++) begin
      offer_key(batch[i], i == batch.size() - 1);
    end
    batch.delete();
  endtask

  // Drop valid and wait until every sorted key is back and the engine is quiet.
  task automatic settle();
    key_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input mode_t m);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int          sent;
    int          set_idx;
    int          set_size;
    logic [31:0] k;
    mode_t       dir_modes [4];

    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_data         <= '0;
    key_chan.valid   <= 1'b0;
    key_chan.key     <= '0;
    key_chan.last_in <= 1'b0;
    burst_left = 0;
    dir_modes  = '{MODE_ASC_UNSIGNED, MODE_DESC_SIGNED, MODE_DESC_UNSIGNED, MODE_ASC_SIGNED};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Edge keys with a duplicate under every compare mode, then a one-key set.
    foreach (dir_modes[m]) begin
      set_mode(dir_modes[m]);
      foreach (EDGE_KEYS[j]) batch.push_back(EDGE_KEYS[j]);
      send_batch();
    end
    batch.push_back(32'h8000_0001);
    send_batch();

    sent    = 0;
    set_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      // Leave the first two sets back to back so the long receiver hold meets a waiting sender.
      if (set_idx > 1 && $urandom_range(0, 2) == 0) begin
        set_mode(mode_t'($urandom_range(0, 3)));
      end
      case ($urandom_range(0, 9))
        0:       set_size = $urandom_range(MAX_KEYS + 1, MAX_KEYS + 8);
        1, 2:    set_size = $urandom_range(13, MAX_KEYS);
        default: set_size = $urandom_range(1, 12);
      endcase
      // First set overruns by one, so its last key is the one dropped.
      if (set_idx == 0) begin
        set_size = MAX_KEYS + 1;
      end
      for (int i = 0; i < set_size; i++) begin
        case ($urandom_range(0, 7))
          0:       k = '0;
          1:       k = '1;
          2:       k = {1'b1, 28'h0, 3'($urandom_range(0, 7))};
          3:       k = {1'b0, {28{1'b1}}, 3'($urandom_range(0, 7))};
          4:       k = 32'($urandom_range(0, 7));
          default: k = $urandom();
        endcase
        batch.push_back(k);
      end
      send_batch();
      sent += set_size;
      set_idx++;
    end
    set_mode(MODE_DESC_SIGNED);
    batch.push_back(32'hFFFF_FFFE);
    batch.push_back(32'h0000_0002);
    send_batch();
    settle();

    if (fail_count == 0 && pending_count == 0) begin
      $display("insertion_sort_engine test passed");
    end else begin
      $display("insertion_sort_engine test failed");
    end
    $finish;
  end

  // Receiver: an 8-bit ready pattern redrawn each time the 6-bit phase wraps, plus one long hold.
  initial begin
    logic [7:0] stall_pattern;
    logic [5:0] phase;
    int         taken;
    logic       held;

    stall_pattern = 8'hFF;
    phase         = '0;
    taken         = 0;
    held          = 1'b0;
    sorted_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sorted_chan.valid && sorted_chan.ready) begin
        taken++;
      end
      if (!held && taken >= HOLD_AT) begin
        held = 1'b1;
        sorted_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (phase == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_pattern = 8'hFF;
            1:       stall_pattern = 8'h01;
            default: stall_pattern = 8'($urandom_range(0, 255));
          endcase
        end
        sorted_chan.ready <= stall_pattern[phase[2:0]];
        phase++;
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (key_chan.valid && key_chan.ready) ||
        (sorted_chan.valid && sorted_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("insertion_sort_engine test failed");
      $finish;
    end
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/ise_pkg.sv
rtl/ise_in_if.sv
rtl/ise_out_if.sv
rtl/ise_cell.sv
rtl/insertion_sort_engine.sv
sim/insertion_sort_engine_checker.sv
sim/insertion_sort_engine_tb.sv
